// ===== rtl/core/gmm3_pkg.sv =====
// Shared constants and types for the 3x3 grey-level morphology unit.
package gmm3_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int PIX_W     = 8;
  localparam int WIDTH_W   = 11;
  localparam int HEIGHT_W  = 16;
  localparam int ROW_W     = HEIGHT_W + 1;
  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 5;
  localparam int LINE_W    = 2 * PIX_W;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DILATE = 3'd2;
  localparam logic [2:0] REG_EIGHT  = 3'd3;
  localparam logic [2:0] REG_BINARY = 3'd4;

  localparam logic [PIX_W-1:0] PAD_ERODE  = 8'd255;
  localparam logic [PIX_W-1:0] PAD_BINARY = 8'd1;
  localparam logic [PIX_W-1:0] PAD_DILATE = 8'd0;

  // Write port of the line buffer: {upper, middle} at one column
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [LINE_W-1:0] data;
  } lb_write_t;

endpackage

// ===== rtl/core/gmm3_line_buf.sv =====
// Two-row line buffer in one synchronous memory, with same-column forwarding.
module gmm3_line_buf import gmm3_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  lb_write_t         wr,
  output logic [PIX_W-1:0]  upper,
  output logic [PIX_W-1:0]  middle
);

  logic [LINE_W-1:0] mem [MAX_WIDTH];
  logic [LINE_W-1:0] rd_q;
  logic [LINE_W-1:0] fwd_data;
  logic              fwd;

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Capture a write to the column being read in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (rd_en) begin
      fwd <= wr.en && (wr.addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data <= wr.data;
    end
  end

  assign {upper, middle} = fwd ? fwd_data : rd_q;

endmodule

// ===== rtl/core/grey_morphology_3x3_unit.sv =====
// 3x3 grey-level erosion/dilation over a raster pixel stream: top level.
// Pixels enter in raster order, one item per clock when both sides keep up; each item
// yields at most one result, which appears w_eff+1 items after its pixel, so the
// source sends w_eff+1 flush items after the last pixel of a frame. An item waits in the
// read stage for the line buffer's registered read, then moves to the output register;
// the pipeline accepts a new item every cycle unless the output stalls. Frame size is
// set through the register port; writing width or height restarts the frame. The line
// buffer needs no clearing after reset: rows above the frame are always padded.
module grey_morphology_3x3_unit import gmm3_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // pixel input
  input  logic               pixel_valid,
  output logic               pixel_ready,
  input  logic [PIX_W-1:0]   pixel_in,
  input  logic               flush,
  // result output
  output logic               result_valid,
  input  logic               result_ready,
  output logic [PIX_W-1:0]   pixel_out,
  output logic               frame_last,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  px;
    logic              top;
    logic              bottom;
    logic              left;
    logic              right;
    logic              emit;
    logic              last;
  } stage_t;

  // Configuration
  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic                dilate_mode;
  logic                eight_neighbours;
  logic                binary_image;
  logic                cfg_wr;
  logic [2:0]          cfg_idx;

  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [ROW_W-1:0]    h_ext;
  logic [ROW_W-1:0]    h_plus1;

  // Counters and pipeline
  logic [ADDR_W-1:0]   col;
  logic [ROW_W-1:0]    row;
  logic [WIDTH_W-1:0]  col_inc;
  logic                accept;
  logic                a_fire;
  logic                at_col0;
  stage_t              a;
  stage_t              a_next;

  lb_write_t           lb_wr;
  logic [PIX_W-1:0]    lb_upper;
  logic [PIX_W-1:0]    lb_middle;

  logic [PIX_W-1:0]    win [9];
  logic [PIX_W-1:0]    p [9];
  logic [PIX_W-1:0]    pad;
  logic [PIX_W-1:0]    v_n, v_s, v_w, v_e, v_nw, v_ne, v_sw, v_se;
  logic [PIX_W-1:0]    m0, m1, m2, m3, m4, m5, m6, m7;

  function automatic logic [PIX_W-1:0] pick(input logic mx,
                                            input logic [PIX_W-1:0] x,
                                            input logic [PIX_W-1:0] y);
    if (mx) begin
      return (x > y) ? x : y;
    end
    return (x < y) ? x : y;
  endfunction

  // Register port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= WIDTH_W'(MAX_WIDTH);
      image_height     <= HEIGHT_W'(768);
      dilate_mode      <= 1'b0;
      eight_neighbours <= 1'b0;
      binary_image     <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH:  image_width      <= pwdata[WIDTH_W-1:0];
        REG_HEIGHT: image_height     <= pwdata[HEIGHT_W-1:0];
        REG_DILATE: dilate_mode      <= pwdata[0];
        REG_EIGHT:  eight_neighbours <= pwdata[0];
        REG_BINARY: binary_image     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:  prdata = DATA_W'(image_width);
      REG_HEIGHT: prdata = DATA_W'(image_height);
      REG_DILATE: prdata = DATA_W'(dilate_mode);
      REG_EIGHT:  prdata = DATA_W'(eight_neighbours);
      REG_BINARY: prdata = DATA_W'(binary_image);
      default:    prdata = '0;
    endcase
  end

  // Clamp the frame size to the supported range
  always_comb begin
    if (image_width == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (image_width > WIDTH_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    h_eff   = (image_height == '0) ? HEIGHT_W'(1) : image_height;
    h_ext   = ROW_W'(h_eff);
    h_plus1 = h_ext + ROW_W'(1);
  end

  // Handshake
  assign a_fire      = a.valid && (!result_valid || result_ready);
  assign pixel_ready = !a.valid || a_fire;
  assign accept      = pixel_valid && pixel_ready;

  // Work out the border and emit flags of the incoming item from the counters
  assign at_col0 = (col == '0);
  assign col_inc = WIDTH_W'(col) + WIDTH_W'(1);

  always_comb begin
    a_next.valid  = 1'b1;
    a_next.addr   = col;
    a_next.px     = flush ? '0 : pixel_in;
    a_next.right  = at_col0;
    a_next.last   = at_col0 && (row == h_plus1);
    if (at_col0) begin
      a_next.top    = (row == ROW_W'(2));
      a_next.bottom = (row == h_plus1);
      a_next.left   = (w_eff == WIDTH_W'(1));
      a_next.emit   = (row >= ROW_W'(2)) && (row <= h_plus1);
    end else begin
      a_next.top    = (row == ROW_W'(1));
      a_next.bottom = (row == h_ext);
      a_next.left   = (col == ADDR_W'(1));
      a_next.emit   = (row >= ROW_W'(1)) && (row <= h_ext);
    end
  end

  // Advance the raster counters; restart on size change or end of frame
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cfg_wr && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT)) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (a_next.last) begin
        col <= '0;
        row <= '0;
      end else if (col_inc >= w_eff) begin
        col <= '0;
        row <= row + ROW_W'(1);
      end else begin
        col <= col_inc[ADDR_W-1:0];
      end
    end
  end

  // Read stage: hold the item while the line buffer data arrives
  always_ff @(posedge clk) begin
    if (rst) begin
      a.valid <= 1'b0;
    end else if (accept) begin
      a <= a_next;
    end else if (a_fire) begin
      a.valid <= 1'b0;
    end
  end

  // Line buffer: push the column down one row as the item leaves
  assign lb_wr.en   = a_fire;
  assign lb_wr.addr = a.addr;
  assign lb_wr.data = {lb_middle, a.px};

  gmm3_line_buf u_line_buf (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (col),
    .wr      (lb_wr),
    .upper   (lb_upper),
    .middle  (lb_middle)
  );

  // Window after the shift, newest column on the right
  always_comb begin
    p[0] = win[1]; p[1] = win[2]; p[2] = lb_upper;
    p[3] = win[4]; p[4] = win[5]; p[5] = lb_middle;
    p[6] = win[7]; p[7] = win[8]; p[8] = a.px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (a_fire) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= p[i];
      end
    end
  end

  // Pad the border; drop corners in cross mode by repeating the centre
  always_comb begin
    pad  = dilate_mode ? PAD_DILATE : (binary_image ? PAD_BINARY : PAD_ERODE);
    v_n  = a.top    ? pad : p[1];
    v_s  = a.bottom ? pad : p[7];
    v_w  = a.left   ? pad : p[3];
    v_e  = a.right  ? pad : p[5];
    v_nw = !eight_neighbours ? p[4] : ((a.top || a.left)     ? pad : p[0]);
    v_ne = !eight_neighbours ? p[4] : ((a.top || a.right)    ? pad : p[2]);
    v_sw = !eight_neighbours ? p[4] : ((a.bottom || a.left)  ? pad : p[6]);
    v_se = !eight_neighbours ? p[4] : ((a.bottom || a.right) ? pad : p[8]);
    m0 = pick(dilate_mode, p[4], v_n);
    m1 = pick(dilate_mode, v_s, v_w);
    m2 = pick(dilate_mode, v_e, v_nw);
    m3 = pick(dilate_mode, v_ne, v_sw);
    m4 = pick(dilate_mode, m0, m1);
    m5 = pick(dilate_mode, m2, m3);
    m6 = pick(dilate_mode, m4, m5);
    m7 = pick(dilate_mode, m6, v_se);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (a_fire) begin
      result_valid <= a.emit;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire && a.emit) begin
      pixel_out  <= m7;
      frame_last <= a.last;
    end
  end

  // Checks
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !a.valid |-> pixel_ready)
    else $error("input stalled with an empty read stage");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && a_next.last) |=> (col == '0 && row == '0))
    else $error("counters not cleared after the last item of a frame");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    WIDTH_W'(col) < w_eff)
    else $error("column counter beyond the row width");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    row <= h_plus1)
    else $error("row counter beyond the frame");

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    (a_fire && a.last) |=> (result_valid && frame_last))
    else $error("end of frame item produced no result");

endmodule

// ===== bench/tb_grey_morphology_3x3_unit.sv =====
// Self-checking testbench for the 3x3 grey-level erosion/dilation unit.
module tb_grey_morphology_3x3_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import gmm3_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1650;
  localparam int LIMIT_NS     = 10_000_000;

  // Phase shapes for the random part
  localparam int PH_FULL   = 0;
  localparam int PH_NOISE  = 1;
  localparam int PH_MODE   = 2;
  localparam int PH_BROKEN = 3;
  localparam int PH_FLUSHY = 4;

  // Pixel content styles
  localparam int CONTENT_FULL    = 0;
  localparam int CONTENT_BINARY  = 1;
  localparam int CONTENT_EXTREME = 2;

  // Receiver stall patterns
  localparam int RDY_ALWAYS   = 0;
  localparam int RDY_COIN     = 1;
  localparam int RDY_SPARSE   = 2;
  localparam int RDY_PERIODIC = 3;

  typedef struct packed {
    logic [PIX_W-1:0] level;
    logic             last;
  } morph_result_t;

  // Window predictor plus the queue of results it still expects
  class morph_tracker;
    logic [PIX_W-1:0]    upper_row [MAX_WIDTH];
    logic [PIX_W-1:0]    middle_row [MAX_WIDTH];
    logic [PIX_W-1:0]    win [9];
    int                  col;
    int                  row;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic                dilate;
    logic                eight;
    logic                binary;
    morph_result_t       expected_q [$];
    int unsigned         errors;

    function new();
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
      col        = 0;
      row        = 0;
      width_reg  = WIDTH_W'(1024);
      height_reg = HEIGHT_W'(768);
      dilate     = 1'b0;
      eight      = 1'b0;
      binary     = 1'b0;
      errors     = 0;
    endfunction

    task report(input string what);
      errors++;
      $display("%0t ns  mismatch: %s", $time, what);
    endtask

    function int eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return int'(width_reg);
    endfunction

    function int eff_height();
      return (height_reg == 0) ? 1 : int'(height_reg);
    endfunction

    function logic [DATA_W-1:0] reg_mask(input logic [2:0] idx);
      case (idx)
        REG_WIDTH:  return DATA_W'((1 << WIDTH_W) - 1);
        REG_HEIGHT: return DATA_W'((1 << HEIGHT_W) - 1);
        default:    return DATA_W'(1);
      endcase
    endfunction

    function logic [DATA_W-1:0] register_value(input logic [2:0] idx);
      case (idx)
        REG_WIDTH:  return DATA_W'(width_reg);
        REG_HEIGHT: return DATA_W'(height_reg);
        REG_DILATE: return DATA_W'(dilate);
        REG_EIGHT:  return DATA_W'(eight);
        REG_BINARY: return DATA_W'(binary);
        default:    return '0;
      endcase
    endfunction

    // Size writes restart the frame; mode writes apply from the next item
    function void configure(input logic [2:0] idx, input logic [DATA_W-1:0] data);
      case (idx)
        REG_WIDTH: begin
          width_reg = data[WIDTH_W-1:0];
          col = 0;
          row = 0;
        end
        REG_HEIGHT: begin
          height_reg = data[HEIGHT_W-1:0];
          col = 0;
          row = 0;
        end
        REG_DILATE: dilate = data[0];
        REG_EIGHT:  eight  = data[0];
        REG_BINARY: binary = data[0];
        default: ;
      endcase
    endfunction

    // Advance the window by one accepted item and queue the result it yields
    function void take_pixel(input logic [PIX_W-1:0] level, input logic fl);
      int w, h, x, y, cr, cc, rr, cl;
      logic [PIX_W-1:0] px, pad, acc, v;
      logic last;
      morph_result_t res;
      w    = eff_width();
      h    = eff_height();
      x    = col;
      y    = row;
      px   = fl ? '0 : level;
      pad  = dilate ? PAD_DILATE : (binary ? PAD_BINARY : PAD_ERODE);
      last = 1'b0;
      if (x >= w) x = 0;
      for (int r = 0; r < 3; r++) begin
        win[r*3]   = win[r*3+1];
        win[r*3+1] = win[r*3+2];
      end
      win[2]        = upper_row[x];
      win[5]        = middle_row[x];
      win[8]        = px;
      upper_row[x]  = middle_row[x];
      middle_row[x] = px;
      if (x == 0) begin
        cr = y - 2;
        cc = w - 1;
      end else begin
        cr = y - 1;
        cc = x - 1;
      end
      if (cr >= 0 && cr < h) begin
        acc = win[4];
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            if (!(r == 1 && c == 1) && (eight || r == 1 || c == 1)) begin
              rr = cr + r - 1;
              cl = cc + c - 1;
              v  = (rr < 0 || rr >= h || cl < 0 || cl >= w) ? pad : win[r*3+c];
              if (dilate) acc = (v > acc) ? v : acc;
              else        acc = (v < acc) ? v : acc;
            end
          end
        end
        last      = (cr == h - 1) && (cc == w - 1);
        res.level = acc;
        res.last  = last;
        expected_q.push_back(res);
      end
      if (last) begin
        col = 0;
        row = 0;
      end else begin
        x++;
        if (x >= w) begin
          x = 0;
          y++;
        end
        if (y > h + 1) y = 0;
        col = x;
        row = y;
      end
    endfunction

    task match_result(input logic [PIX_W-1:0] level, input logic last);
      morph_result_t exp_res;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d/%0d with no pixel pending", level, last));
      end else begin
        exp_res = expected_q.pop_front();
        if (level !== exp_res.level)
          report($sformatf("pixel_out %0d, expected %0d", level, exp_res.level));
        if (last !== exp_res.last)
          report($sformatf("frame_last %0d, expected %0d", last, exp_res.last));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               pixel_valid;
  logic               pixel_ready;
  logic [PIX_W-1:0]   pixel_in;
  logic               flush;
  logic               result_valid;
  logic               result_ready;
  logic [PIX_W-1:0]   pixel_out;
  logic               frame_last;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  morph_tracker sb = new();
  int           items_sent = 0;
  int           burst_left = 0;

  grey_morphology_3x3_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel_in     (pixel_in),
    .flush        (flush),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pixel_out    (pixel_out),
    .frame_last   (frame_last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (pixel_valid && pixel_ready) sb.take_pixel(pixel_in, flush);
      if (result_valid && result_ready) sb.match_result(pixel_out, frame_last);
    end
  end

  // Receiver stall pattern: switch between styles, cap any stall run
  int ready_mode = RDY_ALWAYS;
  int mode_left  = 0;
  int period     = 2;
  int tick       = 0;
  int stall_run  = 0;
  always @(negedge clk) begin
    logic rdy;
    if (mode_left == 0) begin
      ready_mode = $urandom_range(RDY_ALWAYS, RDY_PERIODIC);
      mode_left  = $urandom_range(30, 300);
      period     = $urandom_range(2, 9);
    end
    mode_left--;
    tick++;
    case (ready_mode)
      RDY_ALWAYS: rdy = 1'b1;
      RDY_COIN:   rdy = 1'($urandom_range(0, 1));
      RDY_SPARSE: rdy = ($urandom_range(0, 3) == 0);
      default:    rdy = ((tick % period) < (period + 1) / 2);
    endcase
    if (!rdy && stall_run >= 12) rdy = 1'b1;
    stall_run    = rdy ? 0 : stall_run + 1;
    result_ready = rdy;
  end

  // Drive one item, in bursts with random gaps; called and returns at a falling edge
  task send_item(input logic [PIX_W-1:0] level, input logic fl);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        pixel_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    pixel_valid = 1'b1;
    pixel_in    = level;
    flush       = fl;
    do @(posedge clk); while (!pixel_ready);
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  function logic [PIX_W-1:0] pick_level(input int content);
    case (content)
      CONTENT_BINARY:  return PIX_W'($urandom_range(0, 1));
      CONTENT_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return 8'd0;
          1:       return 8'd1;
          2:       return 8'd254;
          default: return 8'd255;
        endcase
      end
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Send items first..first+count-1 of a frame: pixels, then the flush tail
  task send_span(input int w, input int h, input int content, input int flush_pct,
                 input int first, input int count);
    for (int i = first; i < first + count; i++) begin
      if (i < w * h) send_item(pick_level(content), ($urandom_range(0, 99) < flush_pct));
      else           send_item(PIX_W'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // Hold the sender until every expected result is out and the pipeline is empty
  task wait_idle();
    pixel_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register write with junk in the unused bits, then read it back
  task apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] data;
    data    = (DATA_W'($urandom()) & ~sb.reg_mask(idx)) | (value & sb.reg_mask(idx));
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.configure(idx, data);
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== sb.register_value(idx))
      sb.report($sformatf("register %0d reads %0h, expected %0h",
                          idx, prdata, sb.register_value(idx)));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task program_all(input int w_reg, input int h_reg, input logic d, input logic e,
                   input logic b);
    apb_write(REG_WIDTH, DATA_W'(w_reg));
    apb_write(REG_HEIGHT, DATA_W'(h_reg));
    apb_write(REG_DILATE, DATA_W'(d));
    apb_write(REG_EIGHT, DATA_W'(e));
    apb_write(REG_BINARY, DATA_W'(b));
  endtask

  // One phase: settle, program all settings, then drive items of the chosen shape
  task run_phase(input int w_reg, input int h_reg, input int kind);
    int   w, h, total, cut, content, frames;
    logic d, e, b;
    d = 1'($urandom_range(0, 1));
    e = 1'($urandom_range(0, 1));
    b = 1'($urandom_range(0, 1));
    wait_idle();
    program_all(w_reg, h_reg, d, e, b);
    w       = sb.eff_width();
    h       = sb.eff_height();
    total   = w * h + w + 1;
    content = (b && $urandom_range(0, 9) < 7) ? CONTENT_BINARY
                                              : $urandom_range(CONTENT_FULL, CONTENT_EXTREME);
    case (kind)
      PH_NOISE: begin
        repeat ($urandom_range(20, 80))
          send_item(PIX_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      PH_MODE: begin
        cut = $urandom_range(1, total - 1);
        send_span(w, h, content, 0, 0, cut);
        wait_idle();
        apb_write(3'($urandom_range(REG_DILATE, REG_BINARY)), DATA_W'($urandom_range(0, 1)));
        send_span(w, h, content, 0, cut, total - cut);
      end
      PH_BROKEN: begin
        cut = $urandom_range(1, (total - 1 < 60) ? total - 1 : 60);
        send_span(w, h, content, 0, 0, cut);
      end
      PH_FLUSHY: send_span(w, h, content, 10, 0, total);
      default: begin
        frames = (total > 200) ? 1 : $urandom_range(1, 3);
        repeat (frames) send_span(w, h, content, 0, 0, total);
      end
    endcase
  endtask

  // Run limit
  initial begin
    #(LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Main sequence
  initial begin
    logic [PIX_W-1:0] grid [9];
    int base, w_reg, h_reg, pick, kind;
    grid = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd1, 8'd254};
    rst          = 1'b1;
    pixel_valid  = 1'b0;
    pixel_in     = '0;
    flush        = 1'b0;
    result_ready = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed: 3x3 erosion over a cross, extremes in every position
    program_all(3, 3, 1'b0, 1'b0, 1'b0);
    for (int i = 0; i < 9; i++) send_item(grid[i], 1'b0);
    repeat (4) send_item(8'd255, 1'b1);
    // 1x1 dilation over the square, a flush inside the frame counts as zero
    wait_idle();
    program_all(1, 1, 1'b1, 1'b1, 1'b0);
    send_item(8'd200, 1'b1);
    send_item(8'd255, 1'b1);
    send_item(8'd0, 1'b1);
    // 2x1 binary erosion, border padded with one
    wait_idle();
    program_all(2, 1, 1'b0, 1'b1, 1'b1);
    send_item(8'd1, 1'b0);
    send_item(8'd0, 1'b0);
    repeat (3) send_item(8'd255, 1'b1);

    // Size extremes; the widest and tallest frames are cut short by the next size write
    run_phase(0, 3, PH_FULL);
    run_phase(5, 0, PH_FULL);
    run_phase(1024, 1, PH_BROKEN);
    run_phase(2047, 2, PH_BROKEN);
    run_phase(2, 65535, PH_BROKEN);
    run_phase(1, 1, PH_MODE);

    // Random phases, mostly whole frames of small size
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      pick  = $urandom_range(0, 19);
      w_reg = (pick == 0) ? 0 : (pick < 3) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      pick  = $urandom_range(0, 19);
      h_reg = (pick == 0) ? 0 : (pick < 3) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      pick  = $urandom_range(0, 9);
      kind  = (pick < 5) ? PH_FULL : (pick == 5) ? PH_NOISE : (pick < 8) ? PH_MODE
            : (pick == 8) ? PH_BROKEN : PH_FLUSHY;
      run_phase(w_reg, h_reg, kind);
    end

    // Drain and report
    wait_idle();
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/gmm3_pkg.sv
rtl/core/gmm3_line_buf.sv
rtl/core/grey_morphology_3x3_unit.sv
bench/tb_grey_morphology_3x3_unit.sv
